FILE: src/bwma_pkg.sv
// ----------------------------------------------------------------------------
// bwma_pkg: shared types and constants
// Item, command, bucket row and result types, plus the kind and status codes
// used by the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package bwma_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int BKT_W       = 6;
  localparam int MAX_ENTRIES = 4096;
  localparam int CNT_W       = 13;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_CLR = 2'd1;
  localparam logic [1:0] KIND_RPT = 2'd2;
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_W   = 2'd1;
  localparam logic [1:0] STAT_ZERO_DEN = 2'd2;
  localparam logic [1:0] STAT_DROPPED  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [BKT_W-1:0]   bucket;
    logic [15:0]        energy;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [12:0]        entries;
    logic [27:0]        energy_sum;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [23:0] mean_z;
    logic signed [31:0] cov_xx;
    logic signed [31:0] cov_yy;
    logic signed [31:0] cov_zz;
    logic signed [31:0] cov_xy;
    logic signed [31:0] cov_xz;
    logic signed [31:0] cov_yz;
  } out_item_t;

  // Queue entry: deposit with its products already formed.
  // Index 0/1/2 = x/y/z for w1 and w2; xy/xz/yz for wc.
  typedef struct packed {
    logic [1:0]            kind;
    logic [BKT_W-1:0]      bucket;
    logic [15:0]           energy;
    logic [15:0]           wt;
    logic [31:0]           wsq;
    logic [2:0][32:0]      w1;
    logic [2:0][47:0]      w2;
    logic [2:0][47:0]      wc;
  } cmd_t;

  // One bucket row of running sums.
  typedef struct packed {
    logic [CNT_W-1:0]  entry_count;
    logic [28:0]       energy_total;
    logic [28:0]       weight_total;
    logic [44:0]       weight_sq_total;
    logic [2:0][43:0]  sum_w;
    logic [2:0][58:0]  sum_wsq;
    logic [2:0][59:0]  sum_wcr;
    logic              dropped;
  } bkt_t;

endpackage

FILE: src/bwma_front.sv
// ----------------------------------------------------------------------------
// bwma_front: input stage
// Accepts items, drops unused kinds and forms the deposit products in two
// registered multiply stages before pushing into the command queue.
// ----------------------------------------------------------------------------
module bwma_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bwma_pkg::in_item_t              in_data,
  input  logic                            weight_mode,
  input  logic [bwma_pkg::QCNT_W-1:0]     q_count,
  output logic                            q_push,
  output bwma_pkg::cmd_t                  q_push_data
);

  typedef struct packed {
    logic [1:0]                  kind;
    logic [bwma_pkg::BKT_W-1:0]  bucket;
    logic [15:0]                 energy;
    logic [15:0]                 wt;
    logic [31:0]                 wsq;
    logic [2:0][32:0]            wp;
    logic [2:0][31:0]            sq;
    logic [2:0][31:0]            cr;
  } s1_t;

  logic           s1_v_r, s2_v_r;
  s1_t            s1_r, s1_nxt;
  bwma_pkg::cmd_t s2_r, s2_nxt;
  logic [15:0]    pos [3];
  logic           accept, keep;

  // Credit check: count items still in the two stages as queue occupancy.
  assign in_ready = (q_count + {2'b00, s1_v_r} + {2'b00, s2_v_r})
                    < bwma_pkg::QCNT_W'(bwma_pkg::QDEPTH);
  assign accept   = in_valid & in_ready;
  assign keep     = (in_data.kind != bwma_pkg::KIND_NOP);

  always_comb begin
    pos[0] = in_data.pos_x;
    pos[1] = in_data.pos_y;
    pos[2] = in_data.pos_z;
    s1_nxt.kind   = in_data.kind;
    s1_nxt.bucket = in_data.bucket;
    s1_nxt.energy = in_data.energy;
    s1_nxt.wt     = weight_mode ? in_data.energy : 16'd1;
    s1_nxt.wsq    = s1_nxt.wt * s1_nxt.wt;
    for (int k = 0; k < 3; k++) begin
      s1_nxt.wp[k] = {{17{pos[k][15]}}, pos[k]} * {17'd0, s1_nxt.wt};
      s1_nxt.sq[k] = {{16{pos[k][15]}}, pos[k]} * {{16{pos[k][15]}}, pos[k]};
    end
    s1_nxt.cr[0] = {{16{pos[0][15]}}, pos[0]} * {{16{pos[1][15]}}, pos[1]};
    s1_nxt.cr[1] = {{16{pos[0][15]}}, pos[0]} * {{16{pos[2][15]}}, pos[2]};
    s1_nxt.cr[2] = {{16{pos[1][15]}}, pos[1]} * {{16{pos[2][15]}}, pos[2]};
  end

  always_comb begin
    s2_nxt.kind   = s1_r.kind;
    s2_nxt.bucket = s1_r.bucket;
    s2_nxt.energy = s1_r.energy;
    s2_nxt.wt     = s1_r.wt;
    s2_nxt.wsq    = s1_r.wsq;
    for (int k = 0; k < 3; k++) begin
      s2_nxt.w1[k] = s1_r.wp[k];
      s2_nxt.w2[k] = {16'd0, s1_r.sq[k]} * {32'd0, s1_r.wt};
      s2_nxt.wc[k] = {{16{s1_r.cr[k][31]}}, s1_r.cr[k]} * {32'd0, s1_r.wt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept & keep;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

  assign q_push      = s2_v_r;
  assign q_push_data = s2_r;

endmodule

FILE: src/bwma_fifo.sv
// ----------------------------------------------------------------------------
// bwma_fifo: command queue
// Short queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module bwma_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  bwma_pkg::cmd_t               push_data,
  input  logic                         pop,
  output logic                         pop_valid,
  output bwma_pkg::cmd_t               pop_data,
  output logic [bwma_pkg::QCNT_W-1:0]  count
);

  bwma_pkg::cmd_t                slot_r [bwma_pkg::QDEPTH];
  logic [bwma_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [bwma_pkg::QCNT_W-1:0]   cnt_r;
  logic                          do_pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = cnt_r;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: src/bwma_back.sv
// ----------------------------------------------------------------------------
// bwma_back: bucket store and statistics sequencer
// Holds the bucket table, does the read-modify-write for deposits, clears
// buckets, and works out reports with a shared digit multiplier and a
// bit-serial divider.
// ----------------------------------------------------------------------------
module bwma_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  bwma_pkg::cmd_t        q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bwma_pkg::out_item_t   out_data
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_RPT   = 13'b0000000000100,
    S_DEN   = 13'b0000000001000,
    S_SETUP = 13'b0000000010000,
    S_MUL   = 13'b0000000100000,
    S_FIX   = 13'b0000001000000,
    S_NUM   = 13'b0000010000000,
    S_DIV   = 13'b0000100000000,
    S_RND   = 13'b0001000000000,
    S_FIN   = 13'b0010000000000,
    S_OUT   = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_t;

  localparam logic [3:0] JOB_MEAN_X = 4'd0;
  localparam logic [3:0] JOB_MEAN_Y = 4'd1;
  localparam logic [3:0] JOB_MEAN_Z = 4'd2;
  localparam logic [3:0] JOB_COV_XX = 4'd3;
  localparam logic [3:0] JOB_COV_YY = 4'd4;
  localparam logic [3:0] JOB_COV_ZZ = 4'd5;
  localparam logic [3:0] JOB_COV_XY = 4'd6;
  localparam logic [3:0] JOB_COV_XZ = 4'd7;
  localparam logic [3:0] JOB_COV_YZ = 4'd8;

  state_t                            state_r;
  bwma_pkg::bkt_t                    mem [bwma_pkg::NUM_BUCKETS];
  logic [bwma_pkg::NUM_BUCKETS-1:0]  valid_r;
  bwma_pkg::bkt_t                    rd_r, cur, row_new;
  logic                              rd_v_r;
  bwma_pkg::cmd_t                    cmd_r;
  bwma_pkg::out_item_t               res_r, out_data_r, res_init;
  logic                              out_valid_r;

  logic [57:0]   ww_r;
  logic [63:0]   den_r;
  logic [3:0]    job_r;
  logic          mphase_r, mneg_r;
  logic [63:0]   ma_r, mb_r;
  logic [1:0]    mdig_r;
  logic [127:0]  macc_r, prod1_r, num_r;
  logic [127:0]  dn_r, dq_r;
  logic [63:0]   dd_r, drem_r;
  logic          dneg_r;
  logic [6:0]    dcnt_r;

  logic          mem_we, mem_re;
  logic [15:0]   digit;
  logic [79:0]   pp;
  logic [127:0]  pp_sh;
  logic [64:0]   trial;
  logic          fits;
  logic [59:0]   sab;
  logic [43:0]   sa, sb, sj;
  logic [59:0]   sab_mag;
  logic [43:0]   sa_mag, sb_mag, sj_mag;
  logic [23:0]   mean_sat;
  logic [31:0]   cov_sat;
  logic          is_clr, is_acc;

  assign cur    = rd_v_r ? rd_r : '0;
  assign is_clr = (q_data.kind == bwma_pkg::KIND_CLR);
  assign is_acc = (cmd_r.kind == bwma_pkg::KIND_ACC);
  assign q_pop  = (state_r == S_IDLE);
  assign mem_re = (state_r == S_IDLE) && q_valid && !is_clr;
  assign mem_we = (state_r == S_RD) && is_acc;

  // Deposit update; a full bucket only marks the drop.
  always_comb begin
    row_new = cur;
    if (cur.entry_count >= bwma_pkg::CNT_W'(bwma_pkg::MAX_ENTRIES)) begin
      row_new.dropped = 1'b1;
    end else begin
      row_new.entry_count     = cur.entry_count + 1'b1;
      row_new.energy_total    = cur.energy_total + {13'd0, cmd_r.energy};
      row_new.weight_total    = cur.weight_total + {13'd0, cmd_r.wt};
      row_new.weight_sq_total = cur.weight_sq_total + {13'd0, cmd_r.wsq};
      for (int k = 0; k < 3; k++) begin
        row_new.sum_w[k]   = cur.sum_w[k] + {{11{cmd_r.w1[k][32]}}, cmd_r.w1[k]};
        row_new.sum_wsq[k] = cur.sum_wsq[k] + {11'd0, cmd_r.w2[k]};
        row_new.sum_wcr[k] = cur.sum_wcr[k] + {{12{cmd_r.wc[k][47]}}, cmd_r.wc[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cmd_r.bucket] <= row_new;
    if (mem_re) rd_r <= mem[q_data.bucket];
  end

  // Starting point of a report: counts copied, statistics zero.
  always_comb begin
    res_init            = '0;
    res_init.status     = (cur.weight_total == '0) ? bwma_pkg::STAT_ZERO_W
                                                   : bwma_pkg::STAT_OK;
    res_init.entries    = cur.entry_count;
    res_init.energy_sum = cur.energy_total[27:0];
  end

  // Operand selection for the current report job.
  always_comb begin
    sab = '0;
    sa  = '0;
    sb  = '0;
    sj  = '0;
    unique case (job_r)
      JOB_MEAN_X: sj = cur.sum_w[0];
      JOB_MEAN_Y: sj = cur.sum_w[1];
      JOB_MEAN_Z: sj = cur.sum_w[2];
      JOB_COV_XX: begin
        sab = {1'b0, cur.sum_wsq[0]}; sa = cur.sum_w[0]; sb = cur.sum_w[0];
      end
      JOB_COV_YY: begin
        sab = {1'b0, cur.sum_wsq[1]}; sa = cur.sum_w[1]; sb = cur.sum_w[1];
      end
      JOB_COV_ZZ: begin
        sab = {1'b0, cur.sum_wsq[2]}; sa = cur.sum_w[2]; sb = cur.sum_w[2];
      end
      JOB_COV_XY: begin
        sab = cur.sum_wcr[0]; sa = cur.sum_w[0]; sb = cur.sum_w[1];
      end
      JOB_COV_XZ: begin
        sab = cur.sum_wcr[1]; sa = cur.sum_w[0]; sb = cur.sum_w[2];
      end
      JOB_COV_YZ: begin
        sab = cur.sum_wcr[2]; sa = cur.sum_w[1]; sb = cur.sum_w[2];
      end
      default: sj = '0;
    endcase
    sab_mag = sab[59] ? (~sab + 60'd1) : sab;
    sa_mag  = sa[43] ? (~sa + 44'd1) : sa;
    sb_mag  = sb[43] ? (~sb + 44'd1) : sb;
    sj_mag  = sj[43] ? (~sj + 44'd1) : sj;
  end

  // Multiplier digit, divider step and saturation.
  always_comb begin
    digit = mb_r[{mdig_r, 4'd0} +: 16];
    pp    = ma_r * digit;
    pp_sh = {48'd0, pp} << {mdig_r, 4'd0};
    trial = {drem_r, dn_r[127]};
    fits  = (trial >= {1'b0, dd_r});
    if (dneg_r) begin
      mean_sat = (dq_r > 128'd8388608) ? 24'h800000 : (~dq_r[23:0] + 24'd1);
      cov_sat  = (dq_r > 128'd2147483648) ? 32'h80000000 : (~dq_r[31:0] + 32'd1);
    end else begin
      mean_sat = (dq_r > 128'd8388607) ? 24'h7FFFFF : dq_r[23:0];
      cov_sat  = (dq_r > 128'd2147483647) ? 32'h7FFFFFFF : dq_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (is_clr) begin
              valid_r[q_data.bucket] <= 1'b0;
            end else begin
              rd_v_r  <= valid_r[q_data.bucket];
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          if (is_acc) begin
            valid_r[cmd_r.bucket] <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_RPT;
          end
        end
        S_RPT: begin
          if (cur.weight_total == '0) state_r <= S_OUT;
          else state_r <= S_DEN;
        end
        S_DEN:   state_r <= S_SETUP;
        S_SETUP: begin
          if (job_r <= JOB_MEAN_Z) state_r <= S_DIV;
          else if (den_r == '0) state_r <= S_OUT;
          else state_r <= S_MUL;
        end
        S_MUL: if (mdig_r == 2'd3) state_r <= S_FIX;
        S_FIX: state_r <= mphase_r ? S_NUM : S_MUL;
        S_NUM: state_r <= S_DIV;
        S_DIV: if (dcnt_r == 7'd127) state_r <= S_RND;
        S_RND: state_r <= S_FIN;
        S_FIN: state_r <= (job_r == JOB_COV_YZ) ? S_OUT : S_SETUP;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (q_valid) cmd_r <= q_data;
      S_RPT: begin
        res_r <= res_init;
        ww_r  <= cur.weight_total * cur.weight_total;
      end
      S_DEN: begin
        den_r <= {6'd0, ww_r} - {19'd0, cur.weight_sq_total};
        job_r <= JOB_MEAN_X;
      end
      S_SETUP: begin
        drem_r <= '0;
        dq_r   <= '0;
        dcnt_r <= '0;
        if (job_r <= JOB_MEAN_Z) begin
          dn_r   <= {76'd0, sj_mag, 8'd0};
          dd_r   <= {35'd0, cur.weight_total};
          dneg_r <= sj[43];
        end else if (den_r == '0) begin
          res_r.status <= bwma_pkg::STAT_ZERO_DEN;
        end else begin
          mphase_r <= 1'b0;
          ma_r     <= {4'd0, sab_mag};
          mb_r     <= {35'd0, cur.weight_total};
          mneg_r   <= sab[59];
          macc_r   <= '0;
          mdig_r   <= '0;
        end
      end
      S_MUL: begin
        macc_r <= macc_r + pp_sh;
        mdig_r <= mdig_r + 1'b1;
      end
      S_FIX: begin
        if (!mphase_r) begin
          prod1_r  <= mneg_r ? (~macc_r + 128'd1) : macc_r;
          mphase_r <= 1'b1;
          ma_r     <= {20'd0, sa_mag};
          mb_r     <= {20'd0, sb_mag};
          mneg_r   <= sa[43] ^ sb[43];
          macc_r   <= '0;
          mdig_r   <= '0;
        end else begin
          num_r <= mneg_r ? (prod1_r + macc_r) : (prod1_r - macc_r);
        end
      end
      S_NUM: begin
        dneg_r <= num_r[127];
        dn_r   <= num_r[127] ? (~num_r + 128'd1) : num_r;
        dd_r   <= den_r;
      end
      S_DIV: begin
        drem_r <= fits ? 64'(trial - {1'b0, dd_r}) : trial[63:0];
        dq_r   <= {dq_r[126:0], fits};
        dn_r   <= {dn_r[126:0], 1'b0};
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_RND: if ({drem_r, 1'b0} >= {1'b0, dd_r}) dq_r <= dq_r + 128'd1;
      S_FIN: begin
        job_r <= job_r + 1'b1;
        unique case (job_r)
          JOB_MEAN_X: res_r.mean_x <= mean_sat;
          JOB_MEAN_Y: res_r.mean_y <= mean_sat;
          JOB_MEAN_Z: res_r.mean_z <= mean_sat;
          JOB_COV_XX: res_r.cov_xx <= cov_sat;
          JOB_COV_YY: res_r.cov_yy <= cov_sat;
          JOB_COV_ZZ: res_r.cov_zz <= cov_sat;
          JOB_COV_XY: res_r.cov_xy <= cov_sat;
          JOB_COV_XZ: res_r.cov_xz <= cov_sat;
          JOB_COV_YZ: begin
            res_r.cov_yz <= cov_sat;
            res_r.status <= cur.dropped ? bwma_pkg::STAT_DROPPED : bwma_pkg::STAT_OK;
          end
          default: res_r.status <= res_r.status;
        endcase
      end
      S_OUT: if (!out_valid_r || out_ready) out_data_r <= res_r;
      default: dcnt_r <= dcnt_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/bucket_weighted_moment_accumulator.sv
// ----------------------------------------------------------------------------
// bucket_weighted_moment_accumulator: per-bucket weighted moment sums
// Sixty-four buckets of running sums with weighted mean and covariance
// reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item per transfer: accumulate a
//   deposit, clear a bucket, or report a bucket. Only a report produces a
//   transfer on out_valid/out_ready/out_data. cfg_we/cfg_wdata write the
//   weight mode (1: weight by energy, 0: unit weight); write it only while
//   the block is idle.
//   Items pass two product stages, a four-entry command queue and the
//   back end. An accumulate reads the bucket table in S_IDLE and writes it
//   back in S_RD; a clear only resets the bucket's valid bit in S_IDLE. A
//   report runs three 128-step divisions for the means and six
//   multiply/128-step divide passes for the covariances, all on one shared
//   multiplier and one bit-serial divider; a zero weight total or a zero
//   covariance denominator ends the report early.
//   Reset clears all buckets at once through per-bucket valid bits and sets
//   the weight mode to 1; no sweep is needed.
//   A stalled receiver holds the finished result in the output register;
//   the back end keeps taking accumulates and clears until a second report
//   is ready, and the front end stops accepting when the queue is full.
// ----------------------------------------------------------------------------
module bucket_weighted_moment_accumulator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bwma_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bwma_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  logic                         weight_mode_r;
  logic                         q_push, q_pop, q_valid;
  bwma_pkg::cmd_t               q_push_data, q_data;
  logic [bwma_pkg::QCNT_W-1:0]  q_count;

  // Hold the weight mode; it is sampled as each deposit enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_mode_r <= 1'b1;
    end else if (cfg_we) begin
      weight_mode_r <= cfg_wdata;
    end
  end

  // Front: accept, drop unused kinds, form deposit products.
  bwma_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .weight_mode (weight_mode_r),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Queue decouples the front stages from the bucket sequencer.
  bwma_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  // Back: bucket table update and report arithmetic.
  bwma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
